// ===== sv/tcsr_pkg.sv =====
package tcsr_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_SCREEN_ROWS = 480;
   localparam int DEF_TEX_WORDS   = 4096;

   // Fixed field and state widths
   localparam int DIM_W    = 7;   // tex_width / tex_height registers
   localparam int TCOL_W   = 6;   // texture column
   localparam int TROW_W   = 6;   // texture row
   localparam int SPAN_W   = 12;  // signed span rows
   localparam int FRAC_W   = 22;  // fraction of the wall hit point
   localparam int DEN_W    = 18;  // divisor width (3 * distance)
   localparam int ADDR_W   = 13;  // texel address before range check
   localparam int COLOR_W  = 24;
   localparam int PIX_W    = 10;
   localparam int IDX_W    = 12;
   localparam int QPOS_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [COLOR_W-1:0] KEY_COLOR = 24'h00ff00;
   localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;
   localparam logic [DIM_W-1:0]   DIM_MIN   = 7'd1;
   localparam logic [DIM_W-1:0]   DIM_MAX   = 7'd64;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_COLUMN = 2'd1,
      CMD_ROW    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_COL_MUL,
      ST_COL_SCALE,
      ST_COL_DIV,
      ST_COL_COMMIT,
      ST_ROW_CHECK,
      ST_ROW_DIV,
      ST_ROW_ADDR,
      ST_ROW_READ,
      ST_ROW_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic load_wr;
      logic div_start;
      logic div_row;
      logic col_frac;
      logic col_scale;
      logic col_commit;
      logic row_addr;
      logic row_read;
      logic row_emit;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic row_ok;
      logic div_busy;
   } dp_status_type;

   // Saturate a written texture dimension to 1..64
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) r = DIM_MIN;
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

endpackage

// ===== sv/tcsr_div.sv =====
module tcsr_div import tcsr_pkg::*; #(
   parameter int NUM_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   // One restoring step per cycle, quotient bits shift into num_ff
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

// ===== sv/tcsr_ctrl.sv =====
module tcsr_ctrl import tcsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_cmd,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   state_type state_ff, state_in;
   cmd_type   req_code;

   assign req_code = cmd_type'(req_cmd);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_code)
                  CMD_LOAD:   state_in = ST_LOAD;
                  CMD_COLUMN: state_in = ST_COL_MUL;
                  CMD_ROW:    state_in = ST_ROW_CHECK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:       state_in = ST_IDLE;
         ST_COL_MUL:    state_in = ST_COL_SCALE;
         ST_COL_SCALE:  state_in = ST_COL_DIV;
         ST_COL_DIV: begin
            if (!status.div_busy) state_in = ST_COL_COMMIT;
         end
         ST_COL_COMMIT: state_in = ST_IDLE;
         ST_ROW_CHECK: begin
            if (status.row_ok) state_in = ST_ROW_DIV;
            else state_in = ST_IDLE;
         end
         ST_ROW_DIV: begin
            if (!status.div_busy) state_in = ST_ROW_ADDR;
         end
         ST_ROW_ADDR:   state_in = ST_ROW_READ;
         ST_ROW_READ:   state_in = ST_ROW_EMIT;
         ST_ROW_EMIT:   state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOAD:       cmd.load_wr = 1'b1;
         ST_COL_MUL: begin
            cmd.col_frac  = 1'b1;
            cmd.div_start = 1'b1;
         end
         ST_COL_SCALE:  cmd.col_scale = 1'b1;
         ST_COL_DIV:    cmd = '0;
         ST_COL_COMMIT: cmd.col_commit = 1'b1;
         ST_ROW_CHECK: begin
            cmd.div_row   = 1'b1;
            cmd.div_start = status.row_ok;
         end
         ST_ROW_DIV:    cmd = '0;
         ST_ROW_ADDR:   cmd.row_addr = 1'b1;
         ST_ROW_READ:   cmd.row_read = 1'b1;
         ST_ROW_EMIT:   cmd.row_emit = 1'b1;
         default:       cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/tcsr_dp.sv =====
module tcsr_dp import tcsr_pkg::*; #(
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int TEX_WORDS   = DEF_TEX_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [IDX_W-1:0]      req_texel_index,
   input  logic [COLOR_W-1:0]    req_texel_color,
   input  logic [PIX_W-1:0]      req_column_x,
   input  logic [QPOS_W-1:0]     req_wall_dist,
   input  logic                  req_side,
   input  logic [QPOS_W-1:0]     req_cam_pos_x,
   input  logic [QPOS_W-1:0]     req_cam_pos_y,
   input  logic signed [QPOS_W-1:0] req_ray_dir_x,
   input  logic signed [QPOS_W-1:0] req_ray_dir_y,
   input  logic [PIX_W-1:0]      req_row_y,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata,
   output logic                  rsp_strobe,
   output logic [PIX_W-1:0]      rsp_pixel_x,
   output logic [PIX_W-1:0]      rsp_pixel_y,
   output logic [COLOR_W-1:0]    rsp_pixel_color
);

   localparam int NUM_W  = $clog2(SCREEN_ROWS * 256 + 1);
   localparam int AW     = $clog2(TEX_WORDS);
   localparam int HALF   = SCREEN_ROWS / 2;
   localparam int LH_MAX = 2 * SCREEN_ROWS;

   // Captured item
   logic [IDX_W-1:0]          idx_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic [PIX_W-1:0]          colx_ff;
   logic [QPOS_W-1:0]         dist_ff;
   logic                      side_ff;
   logic [QPOS_W-1:0]         posx_ff, posy_ff;
   logic signed [QPOS_W-1:0]  rayx_ff, rayy_ff;
   logic [PIX_W-1:0]          rowy_ff;

   // Configuration and column state
   logic [DIM_W-1:0]          tw_ff, th_ff;
   logic signed [SPAN_W-1:0]  ss_ff, ss_in, se_ff, se_in;
   logic [TCOL_W-1:0]         tcol_ff, tcol_in;
   logic [PIX_W-1:0]          ccol_ff;

   // Working registers
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [DIM_W-1:0]          craw_ff, craw_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic                      addr_ok_ff;
   logic [COLOR_W-1:0]        rd_ff;
   logic                      strobe_ff, strobe_in;
   logic [PIX_W-1:0]          px_ff, py_ff;
   logic [COLOR_W-1:0]        pc_ff;

   logic [COLOR_W-1:0]        mem [TEX_WORDS];

   logic [NUM_W-1:0]          div_num, quot;
   logic [DEN_W-1:0]          div_den, den3;
   logic                      div_busy;
   logic                      row_ok;

   // Capture the item at acceptance
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff   <= req_texel_index;
         color_ff <= req_texel_color;
         colx_ff  <= req_column_x;
         dist_ff  <= req_wall_dist;
         side_ff  <= req_side;
         posx_ff  <= req_cam_pos_x;
         posy_ff  <= req_cam_pos_y;
         rayx_ff  <= req_ray_dir_x;
         rayy_ff  <= req_ray_dir_y;
         rowy_ff  <= req_row_y;
      end
   end

   // Texture memory: load port and registered read
   always_ff @(posedge clock) begin
      if (cmd.load_wr && ({1'b0, idx_ff} < (IDX_W + 1)'(TEX_WORDS))) begin
         mem[idx_ff[AW-1:0]] <= color_ff;
      end
      if (cmd.row_read) begin
         rd_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   // Hit point fraction: pos + dist * ray, low 22 bits
   logic [QPOS_W-1:0]          pos_sel;
   logic signed [QPOS_W-1:0]   ray_sel;
   logic signed [2*QPOS_W:0]   dr_prod;

   always_comb begin
      pos_sel = side_ff ? posx_ff : posy_ff;
      ray_sel = side_ff ? rayx_ff : rayy_ff;
      dr_prod = $signed({1'b0, dist_ff}) * ray_sel;
      frac_in = dr_prod[FRAC_W-1:0] + {pos_sel[7:0], 14'd0};
   end

   // Scale the fraction to a texture column
   logic [FRAC_W+DIM_W-1:0] scale_prod;

   always_comb begin
      scale_prod = {{DIM_W{1'b0}}, frac_ff} * {{FRAC_W{1'b0}}, tw_ff};
      craw_in    = scale_prod[FRAC_W+DIM_W-1:FRAC_W];
   end

   // Span and mirrored column from the divider quotient
   logic [NUM_W-1:0]        lh;
   logic signed [SPAN_W-1:0] lh_half;
   logic                    mirror;
   logic [DIM_W-1:0]        cmir;

   always_comb begin
      if (dist_ff == '0) lh = NUM_W'(SCREEN_ROWS);
      else if (quot > NUM_W'(LH_MAX)) lh = NUM_W'(LH_MAX);
      else lh = quot;
      lh_half = $signed(SPAN_W'(lh >> 1));
      ss_in   = $signed(SPAN_W'(HALF)) - lh_half;
      se_in   = $signed(SPAN_W'(HALF)) + lh_half;
      mirror  = (!side_ff && (rayx_ff > 0)) || (side_ff && (rayy_ff < 0));
      cmir    = mirror ? (tw_ff - craw_ff - 1'b1) : craw_ff;
      tcol_in = cmir[TCOL_W-1:0];
   end

   // Row range check and row divider operands
   logic signed [SPAN_W-1:0] ys, lo, diff;
   logic [SPAN_W+DIM_W-1:0]  row_prod;

   always_comb begin
      ys       = $signed({{(SPAN_W-PIX_W){1'b0}}, rowy_ff});
      lo       = (ss_ff < 0) ? '0 : ss_ff;
      row_ok   = !(ys < lo) && (32'(rowy_ff) < SCREEN_ROWS) && (ys < se_ff);
      diff     = ys - ss_ff;
      row_prod = {{DIM_W{1'b0}}, diff} * {{SPAN_W{1'b0}}, th_ff};
      den3     = {1'b0, dist_ff, 1'b0} + {2'b00, dist_ff};
      if (cmd.div_row) begin
         div_num = NUM_W'(row_prod);
         div_den = DEN_W'(se_ff - ss_ff);
      end else begin
         div_num = NUM_W'(SCREEN_ROWS * 256);
         div_den = den3;
      end
   end

   tcsr_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign status = {row_ok, div_busy};

   // Texel address from texture row and column
   logic [ADDR_W-1:0] trow_prod;

   always_comb begin
      trow_prod = {{(ADDR_W-TROW_W){1'b0}}, quot[TROW_W-1:0]}
                * {{(ADDR_W-DIM_W){1'b0}}, tw_ff};
      addr_in   = trow_prod + {{(ADDR_W-TCOL_W){1'b0}}, tcol_ff};
   end

   // Drop keyed texels and out-of-range addresses
   assign strobe_in = cmd.row_emit && addr_ok_ff && (rd_ff != KEY_COLOR);

   // Working and output payload registers
   always_ff @(posedge clock) begin
      if (cmd.col_frac)  frac_ff <= frac_in;
      if (cmd.col_scale) craw_ff <= craw_in;
      if (cmd.row_addr) begin
         addr_ff    <= addr_in;
         addr_ok_ff <= (32'(addr_in) < TEX_WORDS);
      end
      if (cmd.row_emit) begin
         px_ff <= ccol_ff;
         py_ff <= rowy_ff;
         pc_ff <= rd_ff;
      end
   end

   // Configuration, column state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff     <= DIM_RESET;
         th_ff     <= DIM_RESET;
         ss_ff     <= '0;
         se_ff     <= '0;
         tcol_ff   <= '0;
         ccol_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TEX_WIDTH:  tw_ff <= sat_dim(csr_wdata);
               CSR_TEX_HEIGHT: th_ff <= sat_dim(csr_wdata);
               default:        tw_ff <= tw_ff;
            endcase
         end
         if (cmd.col_commit) begin
            ss_ff   <= ss_in;
            se_ff   <= se_in;
            tcol_ff <= tcol_in;
            ccol_ff <= colx_ff;
         end
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = pc_ff;

endmodule

// ===== sv/textured_column_sprite_renderer_core.sv =====
// Textured sprite column renderer for a raycaster.
// Input channel: an item is taken on a clock edge with start high and busy
// low; req_cmd selects a texel load, a column start or a one-row draw.
// A column start runs the multiply, scale, divide and commit states; a row
// draw runs check, divide, address, read and emit, or only the check when
// the row is off the span. The divide states wait on the shared divider,
// one bit per cycle over NUM_W = clog2(SCREEN_ROWS*256+1) bits (17 at the
// default) for column height and texture row. One item is in work at a time.
// Result channel: a pixel write shows on rsp_pixel_* for one cycle with
// rsp_strobe high, the cycle after the row item completes; rows outside
// the span or screen, key-coloured texels and out-of-range texel addresses
// give no write. The receiver cannot stall the channel and need not.
// Configuration: csr_we writes tex_width (index 0) or tex_height (index 1),
// saturated to 1..64; the user must write only while idle (not enforced).
// Reset: synchronous; dimensions return to 64, the span and column clear.
// The texture memory is not cleared and must be loaded before use.
module textured_column_sprite_renderer_core import tcsr_pkg::*; #(
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int TEX_WORDS   = DEF_TEX_WORDS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_texel_index,
   input  logic [COLOR_W-1:0]       req_texel_color,
   input  logic [PIX_W-1:0]         req_column_x,
   input  logic [QPOS_W-1:0]        req_wall_dist,
   input  logic                     req_side,
   input  logic [QPOS_W-1:0]        req_cam_pos_x,
   input  logic [QPOS_W-1:0]        req_cam_pos_y,
   input  logic signed [QPOS_W-1:0] req_ray_dir_x,
   input  logic signed [QPOS_W-1:0] req_ray_dir_y,
   input  logic [PIX_W-1:0]         req_row_y,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_wdata,
   output logic                     rsp_strobe,
   output logic [PIX_W-1:0]         rsp_pixel_x,
   output logic [PIX_W-1:0]         rsp_pixel_y,
   output logic [COLOR_W-1:0]       rsp_pixel_color
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tcsr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (dp_status),
      .cmd     (dp_cmd),
      .busy    (busy)
   );

   tcsr_dp #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .TEX_WORDS   (TEX_WORDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_texel_index (req_texel_index),
      .req_texel_color (req_texel_color),
      .req_column_x    (req_column_x),
      .req_wall_dist   (req_wall_dist),
      .req_side        (req_side),
      .req_cam_pos_x   (req_cam_pos_x),
      .req_cam_pos_y   (req_cam_pos_y),
      .req_ray_dir_x   (req_ray_dir_x),
      .req_ray_dir_y   (req_ray_dir_y),
      .req_row_y       (req_row_y),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color)
   );

endmodule

// ===== tb/sv/pixel_write_checker.sv =====
module pixel_write_checker import tcsr_pkg::*; #(
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int TEX_WORDS   = DEF_TEX_WORDS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_texel_index,
   input  logic [COLOR_W-1:0]       req_texel_color,
   input  logic [PIX_W-1:0]         req_column_x,
   input  logic [QPOS_W-1:0]        req_wall_dist,
   input  logic                     req_side,
   input  logic [QPOS_W-1:0]        req_cam_pos_x,
   input  logic [QPOS_W-1:0]        req_cam_pos_y,
   input  logic signed [QPOS_W-1:0] req_ray_dir_x,
   input  logic signed [QPOS_W-1:0] req_ray_dir_y,
   input  logic [PIX_W-1:0]         req_row_y,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_wdata,
   input  logic                     rsp_strobe,
   input  logic [PIX_W-1:0]         rsp_pixel_x,
   input  logic [PIX_W-1:0]         rsp_pixel_y,
   input  logic [COLOR_W-1:0]       rsp_pixel_color,
   output int                       fail_count,
   output int                       pixels_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [COLOR_W-1:0] colour;
   } pixel_write_type;

   // Shadow of the block's texture memory, span and column
   logic [COLOR_W-1:0] texel_mem [0:TEX_WORDS-1];
   int                 span_lo_row;
   int                 span_hi_row;
   logic [TCOL_W-1:0]  tex_col;
   logic [PIX_W-1:0]   draw_column;
   int                 width_reg;
   int                 height_reg;
   pixel_write_type    expected_pixels [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // Clamp a written texture dimension into 1..64
   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   // Column height, span and mirrored texture column for a column start
   task automatic column_setup(input logic [PIX_W-1:0] column,
                               input logic [QPOS_W-1:0] distance,
                               input logic hit_side,
                               input logic [QPOS_W-1:0] pos_x,
                               input logic [QPOS_W-1:0] pos_y,
                               input logic signed [QPOS_W-1:0] ray_x,
                               input logic signed [QPOS_W-1:0] ray_y);
      int          height_px;
      longint      hit;
      longint      hit_frac;
      longint      col;
      if (distance == 0) begin
         height_px = SCREEN_ROWS;
      end else begin
         height_px = (SCREEN_ROWS * 256) / (3 * int'(distance));
         if (height_px > 2 * SCREEN_ROWS) height_px = 2 * SCREEN_ROWS;
      end
      span_lo_row = SCREEN_ROWS / 2 - height_px / 2;
      span_hi_row = SCREEN_ROWS / 2 + height_px / 2;
      // wall hit point in Q.22; the low bits give the floor fraction
      if (!hit_side)
         hit = longint'(pos_y) * 16384 + longint'(distance) * longint'(ray_y);
      else
         hit = longint'(pos_x) * 16384 + longint'(distance) * longint'(ray_x);
      hit_frac = longint'(hit[FRAC_W-1:0]);
      col = (hit_frac * width_reg) >>> FRAC_W;
      if ((!hit_side && ray_x > 0) || (hit_side && ray_y < 0))
         col = width_reg - col - 1;
      tex_col = col[TCOL_W-1:0];
      draw_column = column;
   endtask

   // Expected pixel write, if any, for one row item
   task automatic row_pixel(input logic [PIX_W-1:0] row);
      int              y;
      int              lo;
      int              trow;
      int              addr;
      pixel_write_type px;
      y = int'(row);
      lo = (span_lo_row < 0) ? 0 : span_lo_row;
      if (y < lo || y >= SCREEN_ROWS || y >= span_hi_row) return;
      trow = ((y - span_lo_row) * height_reg) / (span_hi_row - span_lo_row);
      addr = trow * width_reg + int'(tex_col);
      if (addr >= TEX_WORDS) return;
      if (texel_mem[addr] == KEY_COLOR) return;
      px.x = draw_column;
      px.y = row;
      px.colour = texel_mem[addr];
      expected_pixels.push_back(px);
   endtask

   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         expected_pixels.delete();
         fail_count = 0;
         width_reg = 64;
         height_reg = 64;
         span_lo_row = 0;
         span_hi_row = 0;
         tex_col = '0;
         draw_column = '0;
      end else begin
         // compare each pixel write with the oldest expectation
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel write x=%0d y=%0d colour=%06h not expected",
                                         rsp_pixel_x, rsp_pixel_y, rsp_pixel_color));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x)
                  report_mismatch($sformatf("pixel_x %0d, expected %0d", rsp_pixel_x, want.x));
               if (rsp_pixel_y !== want.y)
                  report_mismatch($sformatf("pixel_y %0d, expected %0d", rsp_pixel_y, want.y));
               if (rsp_pixel_color !== want.colour)
                  report_mismatch($sformatf("pixel_color %06h, expected %06h at y=%0d",
                                            rsp_pixel_color, want.colour, want.y));
            end
         end
         // track register writes
         if (csr_we) begin
            if (csr_index == CSR_TEX_WIDTH) width_reg = clamp_dim(csr_wdata);
            else if (csr_index == CSR_TEX_HEIGHT) height_reg = clamp_dim(csr_wdata);
         end
         // advance the shadow state on each accepted item
         if (start && !busy) begin
            case (cmd_type'(req_cmd))
               CMD_LOAD: begin
                  if (int'(req_texel_index) < TEX_WORDS)
                     texel_mem[req_texel_index] = req_texel_color;
               end
               CMD_COLUMN: begin
                  column_setup(req_column_x, req_wall_dist, req_side, req_cam_pos_x,
                               req_cam_pos_y, req_ray_dir_x, req_ray_dir_y);
               end
               CMD_ROW: begin
                  row_pixel(req_row_y);
               end
               default: ;
            endcase
         end
      end
      pixels_awaited = expected_pixels.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   import tcsr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASE_ITEMS   = 130;
   localparam int NUM_PHASES    = 6;
   // texels loaded up front; every phase keeps width * height within this
   localparam int FILL_WORDS    = 256;

   typedef struct {
      cmd_type                 cmd;
      logic [IDX_W-1:0]        texel_index;
      logic [COLOR_W-1:0]      texel_color;
      logic [PIX_W-1:0]        column_x;
      logic [QPOS_W-1:0]       wall_dist;
      logic                    side;
      logic [QPOS_W-1:0]       cam_pos_x;
      logic [QPOS_W-1:0]       cam_pos_y;
      logic signed [QPOS_W-1:0] ray_dir_x;
      logic signed [QPOS_W-1:0] ray_dir_y;
      logic [PIX_W-1:0]        row_y;
   } render_item_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_cmd;
   logic [IDX_W-1:0]         req_texel_index;
   logic [COLOR_W-1:0]       req_texel_color;
   logic [PIX_W-1:0]         req_column_x;
   logic [QPOS_W-1:0]        req_wall_dist;
   logic                     req_side;
   logic [QPOS_W-1:0]        req_cam_pos_x;
   logic [QPOS_W-1:0]        req_cam_pos_y;
   logic signed [QPOS_W-1:0] req_ray_dir_x;
   logic signed [QPOS_W-1:0] req_ray_dir_y;
   logic [PIX_W-1:0]         req_row_y;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DIM_W-1:0]         csr_wdata;
   logic                     rsp_strobe;
   logic [PIX_W-1:0]         rsp_pixel_x;
   logic [PIX_W-1:0]         rsp_pixel_y;
   logic [COLOR_W-1:0]       rsp_pixel_color;
   int                       fail_count;
   int                       pixels_awaited;

   int burst_left = 0;
   int items_sent = 0;
   int cycle_count = 0;

   textured_column_sprite_renderer_core u_top (.*);

   pixel_write_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // item with every field random, so unused fields carry noise
   function automatic render_item_type noise_item();
      render_item_type it;
      it.cmd = cmd_type'(2'($urandom_range(0, 3)));
      it.texel_index = IDX_W'($urandom);
      it.texel_color = COLOR_W'($urandom);
      it.column_x = PIX_W'($urandom);
      it.wall_dist = QPOS_W'($urandom);
      it.side = 1'($urandom);
      it.cam_pos_x = QPOS_W'($urandom);
      it.cam_pos_y = QPOS_W'($urandom);
      it.ray_dir_x = QPOS_W'($urandom);
      it.ray_dir_y = QPOS_W'($urandom);
      it.row_y = PIX_W'($urandom);
      return it;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_colour();
      case ($urandom_range(0, 15))
         0, 1:    return KEY_COLOR;
         2:       return '0;
         3:       return '1;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   function automatic logic [QPOS_W-1:0] pick_distance();
      case ($urandom_range(0, 9))
         0:       return QPOS_W'($urandom_range(0, 4));
         1:       return QPOS_W'($urandom);
         2, 3, 4: return QPOS_W'($urandom_range(200, 2000));
         default: return QPOS_W'($urandom_range(0, 200));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_row();
      if ($urandom_range(0, 4) == 0) return PIX_W'($urandom);
      return PIX_W'($urandom_range(0, 479));
   endfunction

   // present one item after a random gap and hold it until accepted
   task automatic send_item(input render_item_type it);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 15);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_cmd = it.cmd;
      req_texel_index = it.texel_index;
      req_texel_color = it.texel_color;
      req_column_x = it.column_x;
      req_wall_dist = it.wall_dist;
      req_side = it.side;
      req_cam_pos_x = it.cam_pos_x;
      req_cam_pos_y = it.cam_pos_y;
      req_ray_dir_x = it.ray_dir_x;
      req_ray_dir_y = it.ray_dir_y;
      req_row_y = it.row_y;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
      if (it.cmd != CMD_NONE) items_sent++;
   endtask

   task automatic send_load(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] colour);
      render_item_type it;
      it = noise_item();
      it.cmd = CMD_LOAD;
      it.texel_index = idx;
      it.texel_color = colour;
      send_item(it);
   endtask

   task automatic send_column(input logic [PIX_W-1:0] column, input logic [QPOS_W-1:0] distance,
                              input logic hit_side,
                              input logic [QPOS_W-1:0] pos_x, input logic [QPOS_W-1:0] pos_y,
                              input logic [QPOS_W-1:0] ray_x, input logic [QPOS_W-1:0] ray_y);
      render_item_type it;
      it = noise_item();
      it.cmd = CMD_COLUMN;
      it.column_x = column;
      it.wall_dist = distance;
      it.side = hit_side;
      it.cam_pos_x = pos_x;
      it.cam_pos_y = pos_y;
      it.ray_dir_x = ray_x;
      it.ray_dir_y = ray_y;
      send_item(it);
   endtask

   task automatic send_row(input logic [PIX_W-1:0] row);
      render_item_type it;
      it = noise_item();
      it.cmd = CMD_ROW;
      it.row_y = row;
      send_item(it);
   endtask

   task automatic send_unknown();
      render_item_type it;
      it = noise_item();
      it.cmd = CMD_NONE;
      send_item(it);
   endtask

   task automatic random_column();
      send_column(PIX_W'($urandom), pick_distance(), 1'($urandom), QPOS_W'($urandom),
                  QPOS_W'($urandom), QPOS_W'($urandom), QPOS_W'($urandom));
   endtask

   // drain all pixel writes, then let a trailing item finish
   task automatic settle();
      start = 1'b0;
      while (pixels_awaited != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      int target;
      int kind;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_LOAD;
      req_texel_index = '0;
      req_texel_color = '0;
      req_column_x = '0;
      req_wall_dist = '0;
      req_side = 1'b0;
      req_cam_pos_x = '0;
      req_cam_pos_y = '0;
      req_ray_dir_x = '0;
      req_ray_dir_y = '0;
      req_row_y = '0;
      csr_we = 1'b0;
      csr_index = CSR_TEX_WIDTH;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // fill the low texels; reads stay below width * height, kept within the fill
      for (int i = 0; i < FILL_WORDS; i++) send_load(IDX_W'(i), pick_colour());

      // directed: row before any column, unknown command
      send_row(10'd0);
      send_unknown();
      // reset dimensions: distance one, span 160..320, rows near the top of the
      // span only, so texture rows stay within the fill
      send_column(10'd77, 16'd256, 1'b1, 16'h1234, 16'h0000, 16'h4000, 16'h4000);
      send_row(10'd160);
      send_row(10'd165);
      send_row(10'd169);
      settle();
      write_csr(CSR_TEX_WIDTH, 7'd16);
      write_csr(CSR_TEX_HEIGHT, 7'd16);
      // zero distance gives a full-screen span; x side, ray x positive mirrors
      send_column(10'd0, 16'd0, 1'b0, 16'h0000, 16'h0180, 16'h7fff, 16'h2000);
      send_row(10'd0);
      send_row(10'd479);
      send_row(10'd480);
      send_row(10'd1023);
      // very near distance saturates the height; y side, ray y negative mirrors,
      // hit point negative
      send_column(10'd1023, 16'd1, 1'b1, 16'h0000, 16'hffff, 16'h8000, 16'h8000);
      send_row(10'd0);
      send_row(10'd240);
      send_row(10'd479);
      // far distance collapses the span to nothing
      send_column(10'd512, 16'hffff, 1'b0, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
      send_row(10'd240);
      // distance one: span 160..320, rows at and just outside its edges
      send_column(10'd77, 16'd256, 1'b1, 16'h1234, 16'h0000, 16'h4000, 16'h4000);
      send_row(10'd159);
      send_row(10'd160);
      send_row(10'd319);
      send_row(10'd320);
      // key-coloured texel at address zero is skipped, then drawn once replaced
      send_load(12'd0, KEY_COLOR);
      send_column(10'd300, 16'd256, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_row(10'd160);
      send_load(12'd0, 24'hffffff);
      send_row(10'd160);

      // random phases, each under its own texture dimensions
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: begin
                  write_csr(CSR_TEX_WIDTH, 7'd1);
                  write_csr(CSR_TEX_HEIGHT, 7'd1);
               end
               2: begin
                  write_csr(CSR_TEX_WIDTH, 7'd127);
                  write_csr(CSR_TEX_HEIGHT, 7'd0);
               end
               3: begin
                  write_csr(CSR_TEX_WIDTH, 7'd0);
                  write_csr(CSR_TEX_HEIGHT, 7'd64);
               end
               4: begin
                  write_csr(CSR_TEX_WIDTH, 7'd64);
                  write_csr(CSR_TEX_HEIGHT, 7'($urandom_range(1, 4)));
               end
               default: begin
                  write_csr(CSR_TEX_WIDTH, 7'($urandom_range(1, 16)));
                  write_csr(CSR_TEX_HEIGHT, 7'($urandom_range(1, 16)));
               end
            endcase
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
               // column start followed by a run of rows
               random_column();
               repeat ($urandom_range(3, 16)) send_row(pick_row());
            end else if (kind < 16) begin
               repeat ($urandom_range(1, 4)) send_load(IDX_W'($urandom), pick_colour());
            end else if (kind < 18) begin
               repeat ($urandom_range(1, 3)) send_row(pick_row());
            end else if (kind == 18) begin
               send_unknown();
            end else begin
               // broken sequence: loads and stray items between column and rows
               random_column();
               send_load(IDX_W'($urandom), pick_colour());
               send_unknown();
               send_row(pick_row());
            end
         end
      end

      // wait out the last pixel writes, then give the verdict
      start = 1'b0;
      while (pixels_awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== textured_column_sprite_renderer_core.f =====
sv/tcsr_pkg.sv
sv/tcsr_div.sv
sv/tcsr_ctrl.sv
sv/tcsr_dp.sv
sv/textured_column_sprite_renderer_core.sv
tb/sv/pixel_write_checker.sv
tb/sv/testbench.sv
